// ----- hw/rtl/sse_pkg.sv -----
// shared types, codes and constants of the sorted set engine
`default_nettype none

package sse_pkg;

    // fixed field widths
    localparam int VALUE_W  = 32;
    localparam int FUNC_W   = 3;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;

    // default store capacity
    localparam int CAPACITY_DEF = 64;

    // function codes
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_DEL    = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_DEL_RANGE = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_ABSENT    = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_BAD_RANGE = 3'd4;

    // what every cell does at each clock edge
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT_LEFT
    } cell_op_t;

    // compare results of one cell against the current key
    typedef struct packed {
        logic lt;   // stored value below the low key
        logic eq;   // stored value equal to the low key
        logic hit;  // stored value inside the key range
    } sse_flags_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RANGE
    } sse_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sse_cell.sv -----
// one storage cell of the sorted chain: holds a value and compares it to the key
`default_nettype none

module sse_cell
    import sse_pkg::*;
(
    input  wire                              clk,
    input  wire cell_op_t                    op,
    input  wire logic                        valid,
    input  wire logic signed [VALUE_W-1:0]   key_low,
    input  wire logic signed [VALUE_W-1:0]   key_high,
    input  wire logic                        left_lt,
    input  wire logic signed [VALUE_W-1:0]   left_data,
    input  wire logic signed [VALUE_W-1:0]   right_data,
    output logic signed [VALUE_W-1:0]        data,
    output sse_flags_t                       flags
);

    logic signed [VALUE_W-1:0] data_reg;
    logic signed [VALUE_W-1:0] data_next;

    // compares against the broadcast key
    always_comb
    begin
        flags.lt  = valid && (data_reg < key_low);
        flags.eq  = valid && (data_reg == key_low);
        flags.hit = valid && !(data_reg < key_low) && !(data_reg > key_high);
    end

    // insert opens a gap at the first cell not below the key, shift closes one
    always_comb
    begin
        data_next = data_reg;
        unique case (op)
            CELL_HOLD:
            begin
                data_next = data_reg;
            end
            CELL_INSERT:
            begin
                if (!flags.lt)
                begin
                    data_next = left_lt ? key_low : left_data;
                end
            end
            CELL_SHIFT_LEFT:
            begin
                if (!flags.lt)
                begin
                    data_next = right_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/sorted_set_engine_top.sv -----
// top level of the sorted set engine: cell chain and request sequencer
//
//  channel  signals                           direction  handshake
//  in       func, value, range_high          to block   in_valid / in_stall
//  out      found, count, status             from block out_valid / out_stall
//
// clear, lookup, insert and single delete accept the word and then execute it
// in a step in which every cell compares against the key and shifts at once.
// a range delete removes one matching value per cycle through the chain until
// no value in the range is left, and then loads its result.
// reset clears the count and the control state; cell contents are left as is.
// a result waits in the output register while out_stall is high; a new word is
// taken meanwhile, and its final step waits until the output register is free.
`default_nettype none

module sorted_set_engine_top
    import sse_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [FUNC_W-1:0]           func,
    input  wire logic signed [VALUE_W-1:0]   value,
    input  wire logic signed [VALUE_W-1:0]   range_high,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic                             found,
    output logic [COUNT_W-1:0]               count,
    output logic [STATUS_W-1:0]              status
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    sse_state_t state_reg;
    sse_state_t state_next;

    logic [FUNC_W-1:0]           func_reg;
    logic signed [VALUE_W-1:0]   low_reg;
    logic signed [VALUE_W-1:0]   high_reg;
    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;
    logic                        found_reg;
    logic                        found_next;

    logic                        out_valid_reg;
    logic                        out_found_reg;
    logic [COUNT_W-1:0]          out_count_reg;
    logic [STATUS_W-1:0]         out_status_reg;

    logic                        out_load;
    logic                        out_found_next;
    logic [STATUS_W-1:0]         out_status_next;

    cell_op_t                    cell_op;
    logic signed [VALUE_W-1:0]   cell_data [CAPACITY];
    sse_flags_t                  cell_flags [CAPACITY];

    logic                        any_eq;
    logic                        any_hit;
    logic                        slot_free;
    logic                        bad_range;
    logic                        in_accept;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign slot_free = !out_valid_reg || !out_stall;
    assign bad_range = (high_reg < low_reg);

    // chain of cells; inner cells link to both neighbors
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
        logic                        left_lt;
        logic signed [VALUE_W-1:0]   left_data;
        logic signed [VALUE_W-1:0]   right_data;

        if (i == 0)
        begin : g_first
            assign left_lt   = 1'b1;
            assign left_data = low_reg;
        end
        else
        begin : g_inner_left
            assign left_lt   = cell_flags[i-1].lt;
            assign left_data = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_data = cell_data[i];
        end
        else
        begin : g_inner_right
            assign right_data = cell_data[i+1];
        end

        sse_cell u_cell (
            .clk        (clk),
            .op         (cell_op),
            .valid      (IDX < count_reg),
            .key_low    (low_reg),
            .key_high   (high_reg),
            .left_lt    (left_lt),
            .left_data  (left_data),
            .right_data (right_data),
            .data       (cell_data[i]),
            .flags      (cell_flags[i])
        );
    end

    // match flags gathered over the chain
    always_comb
    begin
        any_eq  = 1'b0;
        any_hit = 1'b0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            any_eq  = any_eq  | cell_flags[i].eq;
            any_hit = any_hit | cell_flags[i].hit;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (func_reg == FUNC_DEL_RANGE && !bad_range)
                begin
                    state_next = ST_RANGE;
                end
                else if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RANGE:
            begin
                if (!any_hit && slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer: cell operation, count and result
    always_comb
    begin
        cell_op         = CELL_HOLD;
        count_next      = count_reg;
        found_next      = found_reg;
        out_load        = 1'b0;
        out_found_next  = any_eq;
        out_status_next = STATUS_OK;
        unique case (state_reg)
            ST_IDLE:
            begin
                cell_op = CELL_HOLD;
            end
            ST_EXEC:
            begin
                found_next = any_eq;
                if (func_reg == FUNC_DEL_RANGE && !bad_range)
                begin
                    cell_op = CELL_HOLD;
                end
                else if (slot_free)
                begin
                    out_load = 1'b1;
                    priority if (func_reg == FUNC_CLEAR)
                    begin
                        count_next = '0;
                    end
                    else if (func_reg == FUNC_INSERT)
                    begin
                        priority if (any_eq)
                        begin
                            out_status_next = STATUS_DUPLICATE;
                        end
                        else if (count_reg >= CNT_FULL)
                        begin
                            out_status_next = STATUS_FULL;
                        end
                        else
                        begin
                            cell_op    = CELL_INSERT;
                            count_next = count_reg + CNT_ONE;
                        end
                    end
                    else if (func_reg == FUNC_DEL)
                    begin
                        if (any_eq)
                        begin
                            cell_op    = CELL_SHIFT_LEFT;
                            count_next = count_reg - CNT_ONE;
                        end
                        else
                        begin
                            out_status_next = STATUS_ABSENT;
                        end
                    end
                    else if (func_reg == FUNC_DEL_RANGE)
                    begin
                        out_status_next = STATUS_BAD_RANGE;
                    end
                    else
                    begin
                        out_status_next = STATUS_OK;
                    end
                end
            end
            ST_RANGE:
            begin
                out_found_next = found_reg;
                if (any_hit)
                begin
                    cell_op    = CELL_SHIFT_LEFT;
                    count_next = count_reg - CNT_ONE;
                end
                else if (slot_free)
                begin
                    out_load = 1'b1;
                end
            end
            default:
            begin
                cell_op = CELL_HOLD;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        found_reg <= found_next;
        if (in_accept)
        begin
            func_reg <= func;
            low_reg  <= value;
            high_reg <= range_high;
        end
        if (out_load)
        begin
            out_found_reg  <= out_found_next;
            out_count_reg  <= COUNT_W'(count_next);
            out_status_reg <= out_status_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign found     = out_found_reg;
    assign count     = out_count_reg;
    assign status    = out_status_reg;

endmodule

`default_nettype wire
